>>> hw/rtl/omhw_pkg.sv
// Shared package of the occupancy map high-water tracker.
// Holds codes, fixed field widths and helper functions; depends on nothing.
package omhw_pkg;

  localparam int NUM_SLOTS_DEF = 1024;
  localparam int SLOT_W        = 10;
  localparam int CNT_W         = 11;
  localparam int WORD_W        = 32;
  localparam int BIT_W         = 5;
  localparam int MAX_SLOTS     = 1 << SLOT_W;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUP_INS   = 2'd1,
    ST_FREE_REM  = 2'd2
  } status_t;

  // Smallest power of two at or above x, for x up to 1024; zero maps to zero.
  function automatic logic [CNT_W-1:0] pow2_ceil(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] y;
    logic [3:0]       p;
    y = x - CNT_W'(1);
    p = 4'd0;
    for (int i = 0; i < CNT_W - 1; i++) begin
      if (y[i]) begin
        p = 4'(i + 1);
      end
    end
    if (x == '0) begin
      return '0;
    end
    return CNT_W'(1) << p;
  endfunction

  // Position of the highest set bit of a word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] hi_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        p = BIT_W'(i);
      end
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/omhw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the occupancy words.
module omhw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/omhw_ctrl.sv
// Read-modify-write sequencer of the occupancy tracker: word valid flags,
// counters, downward scan and the output register. Depends on omhw_pkg.
module omhw_ctrl #(
  parameter int NUM_SLOTS = omhw_pkg::NUM_SLOTS_DEF,
  parameter int EFF_SLOTS = (NUM_SLOTS < omhw_pkg::MAX_SLOTS) ? NUM_SLOTS
                                                              : omhw_pkg::MAX_SLOTS,
  parameter int NUM_WORDS = (EFF_SLOTS + omhw_pkg::WORD_W - 1) / omhw_pkg::WORD_W,
  parameter int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,
  input  logic [0:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          ram_wr_en,
  output logic [AW-1:0]                 ram_wr_addr,
  output logic [omhw_pkg::WORD_W-1:0]   ram_wr_data,
  output logic [AW-1:0]                 ram_rd_addr,
  input  logic [omhw_pkg::WORD_W-1:0]   ram_rd_data
);

  localparam int CW = omhw_pkg::CNT_W;
  localparam int WW = omhw_pkg::WORD_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [omhw_pkg::SLOT_W-1:0]  id_r, id_nxt;
  omhw_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                top_r, top_nxt;
  logic [CW-1:0]                cap_r, cap_nxt;
  omhw_pkg::status_t            status_r, status_nxt;
  logic                         chk_r, chk_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  logic [NUM_WORDS-1:0]         vld_r, vld_nxt;
  logic                         rvld_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [39:0]                  out_data_r, out_data_nxt;
  logic [1:0]                   out_user_r, out_user_nxt;

  logic [omhw_pkg::SLOT_W-1:0]  in_id;
  logic [AW-1:0]                id_word;
  logic [omhw_pkg::BIT_W-1:0]   id_bit;
  logic [WW-1:0]                word;
  logic [WW-1:0]                bit_mask;
  logic                         id_exists;
  logic [CW-1:0]                id_plus1;
  logic [CW-1:0]                scan_top;
  logic                         load_out;

  assign in_id    = in_tdata[omhw_pkg::SLOT_W-1:0];
  assign id_word  = AW'(id_r[omhw_pkg::SLOT_W-1:omhw_pkg::BIT_W]);
  assign id_bit   = id_r[omhw_pkg::BIT_W-1:0];
  assign word     = rvld_r ? ram_rd_data : '0;
  assign bit_mask = WW'(1) << id_bit;
  assign id_exists = (32'(id_r) < NUM_SLOTS);
  assign id_plus1 = CW'(id_r) + CW'(1);

  always_comb begin
    logic [AW-1:0] scan_addr;
    scan_addr = (state_r == S_MOD) ? id_word : addr_r;
    scan_top  = CW'({scan_addr, omhw_pkg::hi_bit(word & ~((state_r == S_MOD) ? bit_mask
                                                                          : '0))})
                + CW'(1);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign load_out   = (state_r == S_FIN) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    logic [WW-1:0] new_word;
    state_nxt     = state_r;
    id_nxt        = id_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    cap_nxt       = cap_r;
    status_nxt    = status_r;
    chk_nxt       = chk_r;
    addr_nxt      = addr_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = id_word;
    new_word      = word;
    ram_rd_addr   = AW'(in_id[omhw_pkg::SLOT_W-1:omhw_pkg::BIT_W]);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          id_nxt    = in_id;
          cmd_nxt   = omhw_pkg::cmd_t'(in_tuser[0]);
          chk_nxt   = 1'b0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        state_nxt = S_FIN;
        if (cmd_r == omhw_pkg::CMD_INSERT) begin
          new_word = word | bit_mask;
          if (!id_exists || ((word & bit_mask) != '0)) begin
            status_nxt = omhw_pkg::ST_DUP_INS;
          end else begin
            status_nxt = omhw_pkg::ST_OK;
            ram_wr_en  = 1'b1;
            vld_nxt[id_word] = 1'b1;
            cnt_nxt    = cnt_r + CW'(1);
            if (CW'(id_r) >= cap_r) begin
              cap_nxt = omhw_pkg::pow2_ceil(id_plus1);
            end
            if (CW'(id_r) >= top_r) begin
              top_nxt = id_plus1;
            end
          end
        end else begin
          new_word = word & ~bit_mask;
          if (!id_exists || (CW'(id_r) >= cap_r) || ((word & bit_mask) == '0)) begin
            status_nxt = omhw_pkg::ST_FREE_REM;
          end else begin
            status_nxt = omhw_pkg::ST_OK;
            ram_wr_en  = 1'b1;
            vld_nxt[id_word] = 1'b1;
            cnt_nxt    = cnt_r - CW'(1);
            if (id_plus1 == top_r) begin
              chk_nxt = 1'b1;
              if (new_word != '0) begin
                top_nxt = scan_top;
              end else if (id_word == '0) begin
                top_nxt = '0;
              end else begin
                addr_nxt    = id_word - AW'(1);
                ram_rd_addr = id_word - AW'(1);
                state_nxt   = S_SCAN;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (word != '0) begin
          top_nxt   = scan_top;
          state_nxt = S_FIN;
        end else if (addr_r == '0) begin
          top_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          addr_nxt    = addr_r - AW'(1);
          ram_rd_addr = addr_r - AW'(1);
        end
      end
      S_FIN: begin
        if (load_out) begin
          if (chk_r && (top_r <= (cap_r >> 1))) begin
            cap_nxt = omhw_pkg::pow2_ceil(top_r);
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, cap_nxt, top_r, cnt_r};
          out_user_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    ram_wr_data = new_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      cap_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
      rvld_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      cap_r       <= cap_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      rvld_r      <= vld_r[ram_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    cmd_r      <= cmd_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

>>> hw/rtl/occupancy_map_high_water_tracker_top.sv
// Top level of the occupancy map high-water tracker.
// Instantiates omhw_ram and omhw_ctrl; depends on omhw_pkg.
//
// Each input transfer inserts (tuser 0) or removes (tuser 1) one slot and
// yields exactly one result transfer with the occupied count, the high-water
// offset, the power-of-two capacity and a status code. The occupancy bits sit
// in a RAM of 32-bit words with a registered read. An item goes through
// accept, read-modify-write and a result load that waits for a free output
// register; a remove of the top slot that empties its word scans lower words
// downward, up to NUM_WORDS - 1. The next item is accepted once the result is
// loaded into the output register. The map is empty right after reset, since
// a valid flag per word, cleared by reset, makes unwritten words read zero.
module occupancy_map_high_water_tracker_top #(
  parameter int NUM_SLOTS = omhw_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] slot_id, rest zero
  input  logic [0:0]  in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [10:0] occupied_count, [21:11] high_water,
                                  // [32:22] capacity, rest zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int EFF_SLOTS = (NUM_SLOTS < omhw_pkg::MAX_SLOTS) ? NUM_SLOTS
                                                               : omhw_pkg::MAX_SLOTS;
  localparam int NUM_WORDS = (EFF_SLOTS + omhw_pkg::WORD_W - 1) / omhw_pkg::WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic                        ram_wr_en;
  logic [AW-1:0]               ram_wr_addr;
  logic [omhw_pkg::WORD_W-1:0] ram_wr_data;
  logic [AW-1:0]               ram_rd_addr;
  logic [omhw_pkg::WORD_W-1:0] ram_rd_data;

  omhw_ram #(
    .WIDTH (omhw_pkg::WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  omhw_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .EFF_SLOTS (EFF_SLOTS),
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

endmodule

>>> tb/occupancy_map_high_water_tracker_top_tb.sv
// Testbench of the occupancy map high-water tracker: random and directed inserts and
// removes against a predictor of count, high water, capacity and status per transfer.
// Depends on omhw_pkg and occupancy_map_high_water_tracker_top.
`timescale 1ns / 1ps

module occupancy_map_high_water_tracker_top_tb;
  import omhw_pkg::*;

  localparam int RANDOM_ITEMS = 1925;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 60;

  typedef struct {
    cmd_t             op;
    logic [SLOT_W-1:0] slot;
    int               gap;
    bit               drain;
  } slot_cmd_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] high_water;
    logic [CNT_W-1:0] capacity;
    status_t          status;
  } map_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  occupancy_map_high_water_tracker_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  slot_cmd_t   cmd_queue[$];
  map_report_t pending_reports[$];
  slot_cmd_t   cur_cmd;
  int          fails = 0;
  int          cycle_cnt = 0;

  // Predictor state.
  bit slot_used[MAX_SLOTS];
  int live_slots = 0;
  int hw_mark = 0;
  int table_cap = 0;

  // Stimulus-side view of which slots are occupied.
  bit gen_used[MAX_SLOTS];
  int gen_list[$];

  function automatic int ceil_pow2(int x);
    int p = 1;
    if (x == 0) begin
      return 0;
    end
    while (p < x) begin
      p = p << 1;
    end
    return p;
  endfunction

  function automatic map_report_t update_occupancy(cmd_t op, logic [SLOT_W-1:0] slot);
    map_report_t r;
    int s;
    s = int'(slot);
    r.status = ST_OK;
    if (op == CMD_INSERT) begin
      if (slot_used[s]) begin
        r.status = ST_DUP_INS;
      end else begin
        if (s >= table_cap) begin
          table_cap = ceil_pow2(s + 1);
        end
        slot_used[s] = 1'b1;
        if (s >= hw_mark) begin
          hw_mark = s + 1;
        end
        live_slots++;
      end
    end else begin
      if (s >= table_cap || !slot_used[s]) begin
        r.status = ST_FREE_REM;
      end else begin
        slot_used[s] = 1'b0;
        if (s + 1 == hw_mark) begin
          hw_mark--;
          while (hw_mark > 0 && !slot_used[hw_mark-1]) begin
            hw_mark--;
          end
          if (hw_mark <= table_cap / 2) begin
            table_cap = ceil_pow2(hw_mark);
          end
        end
        live_slots--;
      end
    end
    r.count      = CNT_W'(live_slots);
    r.high_water = CNT_W'(hw_mark);
    r.capacity   = CNT_W'(table_cap);
    return r;
  endfunction

  task automatic add_cmd(cmd_t op, int s, int gap, bit drain);
    slot_cmd_t c;
    int idx[$];
    c.op    = op;
    c.slot  = SLOT_W'(s);
    c.gap   = gap;
    c.drain = drain;
    cmd_queue.push_back(c);
    if (op == CMD_INSERT && !gen_used[s]) begin
      gen_used[s] = 1'b1;
      gen_list.push_back(s);
    end else if (op == CMD_REMOVE && gen_used[s]) begin
      gen_used[s] = 1'b0;
      idx = gen_list.find_first_index(x) with (x == s);
      gen_list.delete(idx[0]);
    end
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      fails++;
    end
  endtask

  task automatic build_stimulus();
    int spans[5];
    int span_hi;
    int len;
    int pick;
    int gap;
    int n;
    int mx[$];
    bit eager;
    bit calm;
    spans = '{1, 7, 39, 299, 1023};

    add_cmd(CMD_REMOVE, 0, 0, 0);
    add_cmd(CMD_INSERT, 0, 0, 0);
    add_cmd(CMD_INSERT, 0, 0, 0);
    add_cmd(CMD_INSERT, 1, 0, 0);
    add_cmd(CMD_INSERT, 1023, 0, 0);
    add_cmd(CMD_INSERT, 512, 0, 0);
    add_cmd(CMD_INSERT, 511, 0, 0);
    add_cmd(CMD_INSERT, 682, 0, 0);
    add_cmd(CMD_INSERT, 341, 0, 0);
    add_cmd(CMD_REMOVE, 1023, 0, 0);
    add_cmd(CMD_REMOVE, 682, 0, 0);
    add_cmd(CMD_REMOVE, 512, 0, 0);
    add_cmd(CMD_REMOVE, 700, 0, 0);
    add_cmd(CMD_REMOVE, 1, 0, 0);
    add_cmd(CMD_REMOVE, 511, 0, 0);
    add_cmd(CMD_REMOVE, 341, 0, 0);
    add_cmd(CMD_REMOVE, 341, 0, 0);
    add_cmd(CMD_REMOVE, 0, 0, 0);
    add_cmd(CMD_INSERT, 31, 0, 0);
    add_cmd(CMD_INSERT, 32, 0, 0);
    add_cmd(CMD_REMOVE, 32, 0, 0);
    add_cmd(CMD_REMOVE, 31, 0, 0);
    add_cmd(CMD_INSERT, 1023, 0, 0);
    add_cmd(CMD_REMOVE, 1023, 0, 0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      span_hi = spans[$urandom_range(0, 4)];
      eager   = $urandom_range(0, 1);
      calm    = ($urandom_range(0, 3) == 0);
      len     = $urandom_range(60, 200);
      for (int k = 0; k < len && n < RANDOM_ITEMS; k++) begin
        gap  = calm ? 0 : $urandom_range(0, 10);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          add_cmd(cmd_t'($urandom_range(0, 1)), $urandom_range(0, MAX_SLOTS - 1), gap,
                  n == 0 || $urandom_range(0, 99) == 0);
        end else if (pick < (eager ? 60 : 35) || gen_list.size() == 0) begin
          add_cmd(CMD_INSERT, $urandom_range(0, span_hi), gap,
                  n == 0 || $urandom_range(0, 99) == 0);
        end else if (pick < 80) begin
          mx = gen_list.max();
          add_cmd(CMD_REMOVE, mx[0], gap, n == 0 || $urandom_range(0, 99) == 0);
        end else begin
          add_cmd(CMD_REMOVE, gen_list[$urandom_range(0, gen_list.size() - 1)], gap,
                  n == 0 || $urandom_range(0, 99) == 0);
        end
        n++;
      end
    end
  endtask

  bit holding;
  int idle_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      idle_cnt = 0;
    end else begin
      holding = in_tvalid;
      if (in_tvalid && in_tready) begin
        pending_reports.push_back(update_occupancy(cur_cmd.op, cur_cmd.slot));
        holding = 1'b0;
      end
      if (!holding) begin
        if (cmd_queue.size() > 0 && idle_cnt >= cmd_queue[0].gap &&
            !(cmd_queue[0].drain && pending_reports.size() > 0)) begin
          cur_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, cur_cmd.slot};
          in_tuser  <= cur_cmd.op;
          idle_cnt = 0;
        end else begin
          in_tvalid <= 1'b0;
          idle_cnt++;
        end
      end
    end
  end

  map_report_t exp_rep;
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no expected result: tdata %h tuser %0d",
                 out_tdata, out_tuser);
          fails++;
        end else begin
          exp_rep = pending_reports.pop_front();
          check_field("occupied_count", exp_rep.count, out_tdata[10:0]);
          check_field("high_water", exp_rep.high_water, out_tdata[21:11]);
          check_field("capacity", exp_rep.capacity, out_tdata[32:22]);
          check_field("status", exp_rep.status, out_tuser);
        end
        stall_left = ((cycle_cnt / 3000) % 3 == 0) ? 0 : $urandom_range(0, 10);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    do begin
      @(posedge clk);
    end while (cmd_queue.size() > 0 || in_tvalid || pending_reports.size() > 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> occupancy_map_high_water_tracker_top.f
hw/rtl/omhw_pkg.sv
hw/rtl/omhw_ram.sv
hw/rtl/omhw_ctrl.sv
hw/rtl/occupancy_map_high_water_tracker_top.sv
tb/occupancy_map_high_water_tracker_top_tb.sv
